@@ rtl/twrl_pkg.sv @@
// Shared types, constants and helpers of the two-window rate limiter.
package twrl_pkg;

  localparam int TWRL_SLOTS = 1024;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 8'd1;

  localparam logic [31:0] SHORT_WINDOW_RST = 32'd1;
  localparam logic [31:0] LONG_WINDOW_RST  = 32'd60;

  typedef struct packed {
    logic        used;
    logic [15:0] service;
    logic [31:0] user;
    logic [31:0] short_start;
    logic [31:0] short_count;
    logic [31:0] long_start;
    logic [31:0] long_count;
    logic [31:0] long_allowed;
  } twrl_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE
  } twrl_state_t;

  // Add a 16-bit amount to a 32-bit counter, pin at all ones on overflow.
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {17'd0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

@@ rtl/twrl_table.sv @@
// Slot table memory with one registered read port, one write port and a clearing pass.
module twrl_table
  import twrl_pkg::*;
#(
  parameter int SLOTS = TWRL_SLOTS,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output twrl_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  twrl_entry_t       wr_data,
  output logic              busy
);

  twrl_entry_t      mem [SLOTS];
  twrl_entry_t      rd_data_r;
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_addr_r;

  // Sweep every entry once after reset; only an unused entry matters afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IDX_W'(SLOTS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

@@ rtl/two_window_rate_limiter.sv @@
// Top level of the two-window rate limiter: stream ports, control sequencer and slot update.
// Flow: an accepted request moves through the check and update states before its verdict is
//   registered onto out_tvalid; the next request waits for the read, check and write-back of
//   the single slot table port pair, and a stalled output holds the write-back stage.
// Reset: rst_n is synchronous, active low; the window registers return to 1 and 60, and a
//   clearing pass over all SLOTS entries (1024 by default) runs with in_tready low.
module two_window_rate_limiter
  import twrl_pkg::*;
#(
  parameter int SLOTS = TWRL_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [9:0] slot, [25:10] service_id, [57:26] user_id, [73:58] amount,
  // [105:74] now_seconds, [137:106] short_limit, [169:138] long_limit, [175:170] zero
  input  logic [175:0]         in_tdata,
  input  logic                 in_tuser,   // [0] lookup_ok
  // Verdict stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] allowed, [7:1] zero
  output logic                 out_tuser,  // [0] status_ok
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);

  // Unpack the request beat.
  logic [9:0]  in_slot;
  logic [15:0] in_service_id;
  logic [31:0] in_user_id;
  logic [15:0] in_amount;
  logic [31:0] in_now_seconds;
  logic [31:0] in_short_limit;
  logic [31:0] in_long_limit;

  assign in_slot        = in_tdata[9:0];
  assign in_service_id  = in_tdata[25:10];
  assign in_user_id     = in_tdata[57:26];
  assign in_amount      = in_tdata[73:58];
  assign in_now_seconds = in_tdata[105:74];
  assign in_short_limit = in_tdata[137:106];
  assign in_long_limit  = in_tdata[169:138];

  // Window length registers; writes beyond the list fall through.
  logic [31:0] short_window_r;
  logic [31:0] long_window_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_window_r <= SHORT_WINDOW_RST;
      long_window_r  <= LONG_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SHORT_WINDOW) begin
        short_window_r <= cfg_data;
      end else if (cfg_index == CFG_LONG_WINDOW) begin
        long_window_r <= cfg_data;
      end
    end
  end

  // Sequencer state and handshake terms.
  twrl_state_t state_r, state_nxt;
  logic        tbl_busy;
  logic        in_fire;
  logic        out_free;
  logic        update_go;
  logic        out_valid_r;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Fold the slot into the table by a reciprocal multiply. With a 26-bit scale the quotient
  // of any 10-bit slot is exact for every table size; the remainder is the table index.
  localparam int          FOLD_SH = 26;
  localparam logic [26:0] FOLD_M  =
    27'(((64'd1 << FOLD_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  logic [36:0]      fold_prod;
  logic [9:0]       fold_quo;
  logic [31:0]      slot_mod;
  logic [IDX_W-1:0] rd_addr;

  assign fold_prod = 37'(in_slot) * 37'(FOLD_M);
  assign fold_quo  = fold_prod[FOLD_SH +: 10];
  assign slot_mod  = {22'd0, in_slot} - ({22'd0, fold_quo} * 32'(SLOTS));
  assign rd_addr   = slot_mod[IDX_W-1:0];

  // Request fields held for the duration of the item.
  logic [IDX_W-1:0] slot_r;
  logic             ok_r;
  logic [15:0]      svc_r;
  logic [31:0]      usr_r;
  logic [15:0]      amt_r;
  logic [31:0]      now_r;
  logic [31:0]      lim1_r;
  logic [31:0]      lim2_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= rd_addr;
      ok_r   <= in_tuser;
      svc_r  <= in_service_id;
      usr_r  <= in_user_id;
      amt_r  <= in_amount;
      now_r  <= in_now_seconds;
      lim1_r <= in_short_limit;
      lim2_r <= in_long_limit;
    end
  end

  // Slot table: read issued on the accepting edge, data valid in the check cycle.
  twrl_entry_t rd_data;
  twrl_entry_t wr_data;
  logic        wr_en;

  twrl_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .busy    (tbl_busy)
  );

  // Check cycle: decide whether the slot restarts and whether the short window rolls over.
  // A restarted slot has short_start equal to now, so it rolls only for a zero window.
  logic reinit_c, short_exp_c;
  logic reinit_r, short_exp_r;

  always_comb begin
    reinit_c = !rd_data.used || (rd_data.service != svc_r) || (rd_data.user != usr_r) ||
               ((now_r - rd_data.long_start) >= long_window_r);
    short_exp_c = reinit_c ? (short_window_r == 32'd0)
                           : ((now_r - rd_data.short_start) >= short_window_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      reinit_r    <= reinit_c;
      short_exp_r <= short_exp_c;
    end
  end

  // Update cycle: accumulate, judge, and form the entry to write back.
  logic [31:0] short_base, long_base, allowed_base;
  logic [31:0] short_new;
  logic        deny;

  always_comb begin
    short_base   = (reinit_r || short_exp_r) ? 32'd0 : rd_data.short_count;
    long_base    = reinit_r ? 32'd0 : rd_data.long_count;
    allowed_base = reinit_r ? 32'd0 : rd_data.long_allowed;
    short_new    = sat_add32(short_base, amt_r);
    deny         = (short_new > lim1_r) || (allowed_base >= lim2_r);

    wr_data.used         = 1'b1;
    wr_data.service      = svc_r;
    wr_data.user         = usr_r;
    wr_data.short_start  = (reinit_r || short_exp_r) ? now_r : rd_data.short_start;
    wr_data.short_count  = short_new;
    wr_data.long_start   = reinit_r ? now_r : rd_data.long_start;
    wr_data.long_count   = sat_add32(long_base, amt_r);
    wr_data.long_allowed = deny ? allowed_base : sat_add32(allowed_base, amt_r);
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs. A failed lookup passes through without touching the table.
  always_comb begin
    in_tready = 1'b0;
    update_go = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = !tbl_busy;
      end
      ST_CHECK: begin
        in_tready = 1'b0;
      end
      ST_UPDATE: begin
        update_go = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign wr_en = update_go && ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register: hold the verdict until the downstream takes the beat.
  logic status_r;
  logic allowed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (update_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      status_r  <= ok_r;
      allowed_r <= ok_r && !deny;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, allowed_r};

  // No request may enter while the table is still being cleared.
  assert property (@(posedge clk) disable iff (!rst_n) tbl_busy |-> !in_tready)
    else $error("request accepted during table clearing");

  // A new verdict beat only follows a completed update cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_UPDATE))
    else $error("verdict raised without an update cycle");

  // A failed lookup is never granted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> !out_tdata[0])
    else $error("grant on a failed lookup");

  // An accepted request moves through the check cycle into the update cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CHECK) ##1 (state_r == ST_UPDATE))
    else $error("sequencer skipped the check or update cycle");

endmodule
